@@ design/ncs_pkg.sv @@
package ncs_pkg;

  // Sizing of the point store and the fixed-point format.
  localparam int MAX_SEGMENTS = 32;
  localparam int FRAC_BITS    = 16;
  localparam int DEPTH        = MAX_SEGMENTS + 1;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int SEG_W        = 6;

  // Divider widths: operands stay below 2^35 in magnitude, numerators are
  // scaled by 2^FRAC_BITS before the divide.
  localparam int DEN_W     = 36;
  localparam int NUM_W     = DEN_W + FRAC_BITS;
  localparam int QUO_W     = NUM_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  // Reciprocal of three for the linear coefficient; exact for magnitudes below 2^33.
  localparam logic [31:0] RECIP3    = 32'haaaaaaab;
  localparam int          RECIP3_SH = 33;

  localparam logic [SEG_W-1:0] RST_SEGMENTS = 6'd24;

  localparam logic signed [63:0] S32MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32MIN = -64'sd2147483648;
  localparam logic signed [63:0] RND    = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_beat_t;

  typedef struct packed {
    logic [SEG_W-1:0]   segment_index;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic               bad_spacing;
    logic               last_segment;
  } out_beat_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_BAD,
    OP_H_DIV,
    OP_S_MF,
    OP_S_MO,
    OP_S_LM,
    OP_S_DF,
    OP_S_LF,
    OP_S_DO,
    OP_B_M,
    OP_O_M1,
    OP_O_M2,
    OP_O_LM,
    OP_O_D3,
    OP_O_LB,
    OP_O_DD,
    OP_O_OUT
  } dp_op_t;

  typedef struct packed {
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] fa;
    logic [IDX_W-1:0] wa;
    logic             pt_we;
    logic             hl_we;
    logic             fo_we;
    logic             c_we;
    logic             mask_fo;
    logic             mask_ck;
    logic             mask_cp;
    logic [SEG_W-1:0] seg;
    logic             last;
    dp_op_t           op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_taken;
  } dp_sts_t;

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Rescale a full product, truncating toward zero, then clamp.
  function automatic logic signed [31:0] qsh(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? RND : 64'sd0);
    return sat32(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [36:0] ext37(input logic signed [31:0] v);
    return {{5{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

@@ design/ncs_div.sv @@
module ncs_div import ncs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUM_W-1:0]        num_mag,
  input  logic [DEN_W-1:0]        den_mag,
  input  logic                    neg,
  output logic                    done,
  output logic signed [QUO_W-1:0] quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W-1:0]     den_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [DEN_W:0]       shifted;
  logic [DEN_W+1:0]     diff;
  logic                 ge;
  logic [NUM_W-1:0]     mag;

  // One restoring step: bring down the next numerator bit and trial subtract.
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= num_mag;
      rem_r  <= '0;
      den_r  <= den_mag;
      neg_r  <= neg;
      zero_r <= (num_mag == '0);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  // A zero divisor with a nonzero numerator yields all ones, which clamps to the signed limits later.
  assign mag  = zero_r ? '0 : quo_r;
  assign quo  = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a run");

endmodule

@@ design/ncs_dp.sv @@
module ncs_dp import ncs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_data,
  input  dp_cmd_t   cmd,
  input  logic      out_stall,
  output logic      out_valid,
  output out_beat_t out_data,
  output dp_sts_t   sts
);

  // Point, width/slope, sweep and curvature stores.
  logic [63:0] pt_mem [DEPTH];
  logic [63:0] hl_mem [DEPTH];
  logic [63:0] fo_mem [DEPTH];
  logic [31:0] c_mem  [DEPTH];

  logic [63:0] pt_a_r, pt_b_r, hl_a_r, hl_b_r, fo_r;
  logic [31:0] c_a_r, c_b_r;

  logic signed [31:0] h_r, m1_r, m2_r, f_r, b_r, c_cur_r;
  logic signed [63:0] p_r;
  logic               bad_r;
  logic               out_valid_r;
  out_beat_t          out_r;

  logic signed [31:0] x_a, x_b, y_a, y_b, h_a, l_a, h_b, l_b;
  logic signed [31:0] fval, oval, ck, cp, h_nxt, c_new, q_sat, b_nxt;
  logic signed [32:0] dx, dy;
  logic signed [36:0] den_s, num_o, dnum, dden, nmag, dmag;
  logic signed [31:0] mul_a, mul_b;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   num_mag;
  logic signed [QUO_W-1:0] quo;
  logic signed [33:0] sum3, sum3_neg, quo3;
  logic [32:0]        mag3;
  logic [33:0]        q3mag;
  logic [64:0]        prod3_r;
  logic               neg3_r;

  always_ff @(posedge clk) begin
    if (cmd.pt_we) pt_mem[cmd.wa] <= in_data;
    if (cmd.hl_we) hl_mem[cmd.wa] <= {h_r, q_sat};
    if (cmd.fo_we) fo_mem[cmd.wa] <= {f_r, q_sat};
    if (cmd.c_we)  c_mem[cmd.wa]  <= c_new;
    pt_a_r <= pt_mem[cmd.ra];
    pt_b_r <= pt_mem[cmd.rb];
    hl_a_r <= hl_mem[cmd.ra];
    hl_b_r <= hl_mem[cmd.rb];
    fo_r   <= fo_mem[cmd.fa];
    c_a_r  <= c_mem[cmd.ra];
    c_b_r  <= c_mem[cmd.rb];
  end

  // Field views of the read registers, with the natural end conditions.
  assign x_a  = pt_a_r[63:32];
  assign y_a  = pt_a_r[31:0];
  assign x_b  = pt_b_r[63:32];
  assign y_b  = pt_b_r[31:0];
  assign h_a  = hl_a_r[63:32];
  assign l_a  = hl_a_r[31:0];
  assign h_b  = hl_b_r[63:32];
  assign l_b  = hl_b_r[31:0];
  assign fval = cmd.mask_fo ? 32'sd0 : $signed(fo_r[63:32]);
  assign oval = cmd.mask_fo ? 32'sd0 : $signed(fo_r[31:0]);
  assign ck   = cmd.mask_ck ? 32'sd0 : $signed(c_a_r);
  assign cp   = cmd.mask_cp ? 32'sd0 : $signed(c_b_r);

  // Interval width and rise.
  assign dx    = {x_a[31], x_a} - {x_b[31], x_b};
  assign dy    = {y_a[31], y_a} - {y_b[31], y_b};
  assign h_nxt = sat32({{31{dx[32]}}, dx});

  // Sweep denominator and offset numerator.
  assign den_s = ext37(h_a) + ext37(h_a) + ext37(h_b) + ext37(h_b) + ext37(m1_r);
  assign num_o = ext37(l_b) + ext37(l_b) + ext37(l_b)
               - ext37(l_a) - ext37(l_a) - ext37(l_a) - ext37(m2_r);

  // Division by three through a reciprocal product, truncated toward zero.
  assign sum3     = {{2{m1_r[31]}}, m1_r} + {{2{m1_r[31]}}, m1_r} + {{2{m2_r[31]}}, m2_r};
  assign sum3_neg = -sum3;
  assign mag3     = sum3[33] ? sum3_neg[32:0] : sum3[32:0];
  assign q3mag    = {2'b00, prod3_r[64:RECIP3_SH]};
  assign quo3     = neg3_r ? -$signed(q3mag) : $signed(q3mag);

  // Back substitution and final coefficient sums.
  assign c_new = sat32(ext64(qsh(p_r)) + ext64(oval));
  assign q_sat = sat32({{(64-QUO_W){quo[QUO_W-1]}}, quo});
  assign b_nxt = sat32({{30{quo3[33]}}, quo3} + ext64(l_a));

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    dnum      = '0;
    dden      = '0;
    unique case (cmd.op)
      OP_H_DIV: begin
        div_start = 1'b1;
        dnum      = {{4{dy[32]}}, dy};
        dden      = ext37(h_nxt);
      end
      OP_S_DF: begin
        div_start = 1'b1;
        dnum      = -ext37(h_b);
        dden      = den_s;
      end
      OP_S_DO: begin
        div_start = 1'b1;
        dnum      = num_o;
        dden      = den_s;
      end
      OP_O_DD: begin
        div_start = 1'b1;
        dnum      = ext37(ck) - ext37(cp);
        dden      = ext37(h_a) + ext37(h_a) + ext37(h_a);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign nmag    = dnum[36] ? -dnum : dnum;
  assign dmag    = dden[36] ? -dden : dden;
  assign num_mag = {nmag[DEN_W-1:0], {FRAC_BITS{1'b0}}};

  ncs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (num_mag),
    .den_mag (dmag[DEN_W-1:0]),
    .neg     (dnum[36] ^ dden[36]),
    .done    (div_done),
    .quo     (quo)
  );

  // Multiplier operand selection.
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    unique case (cmd.op)
      OP_S_MF: begin
        mul_a = h_a;
        mul_b = fval;
      end
      OP_S_MO: begin
        mul_a = h_a;
        mul_b = oval;
      end
      OP_B_M: begin
        mul_a = fval;
        mul_b = cmd.mask_ck ? 32'sd0 : c_cur_r;
      end
      OP_O_M1: begin
        mul_a = ck;
        mul_b = h_a;
      end
      OP_O_M2: begin
        mul_a = h_a;
        mul_b = cp;
      end
      default: begin
        mul_a = 32'sd0;
      end
    endcase
  end

  // Working registers.
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (cmd.op == OP_S_MO || cmd.op == OP_O_M2) m1_r <= qsh(p_r);
    if (cmd.op == OP_S_LM || cmd.op == OP_O_LM) m2_r <= qsh(p_r);
    if (cmd.op == OP_H_DIV) h_r <= h_nxt;
    if (cmd.op == OP_S_LF) f_r <= q_sat;
    if (cmd.op == OP_O_D3) begin
      prod3_r <= {32'd0, mag3} * {33'd0, RECIP3};
      neg3_r  <= sum3[33];
    end
    if (cmd.op == OP_O_LB) b_r <= b_nxt;
    if (cmd.c_we) c_cur_r <= c_new;
    if (cmd.op == OP_O_OUT) begin
      out_r.segment_index <= cmd.seg;
      out_r.coef_a        <= y_a;
      out_r.coef_b        <= b_r;
      out_r.coef_c        <= ck;
      out_r.coef_d        <= q_sat;
      out_r.bad_spacing   <= bad_r;
      out_r.last_segment  <= cmd.last;
    end
  end

  // Spacing flag and result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CLR_BAD) begin
        bad_r <= 1'b0;
      end else if (cmd.op == OP_H_DIV && h_nxt <= 32'sd0) begin
        bad_r <= 1'b1;
      end
      if (cmd.op == OP_O_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.div_done  = div_done;
  assign sts.out_taken = out_valid_r & ~out_stall;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_O_OUT |-> !out_valid_r) else $error("pending result overwritten");

endmodule

@@ design/ncs_ctrl.sv @@
module ncs_ctrl import ncs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cfg_we,
  input  logic [SEG_W-1:0] cfg_wdata,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd
);

  typedef enum logic [23:0] {
    S_LOAD   = 24'h000001,
    S_H_RD   = 24'h000002,
    S_H_DIV  = 24'h000004,
    S_H_WAIT = 24'h000008,
    S_S_RD   = 24'h000010,
    S_S_MF   = 24'h000020,
    S_S_MO   = 24'h000040,
    S_S_LM   = 24'h000080,
    S_S_DF   = 24'h000100,
    S_S_WF   = 24'h000200,
    S_S_DO   = 24'h000400,
    S_S_WO   = 24'h000800,
    S_B_RD   = 24'h001000,
    S_B_MUL  = 24'h002000,
    S_B_WR   = 24'h004000,
    S_O_RD   = 24'h008000,
    S_O_M1   = 24'h010000,
    S_O_M2   = 24'h020000,
    S_O_LM   = 24'h040000,
    S_O_D3   = 24'h080000,
    S_O_W3   = 24'h100000,
    S_O_DD   = 24'h200000,
    S_O_WD   = 24'h400000,
    S_O_OUT  = 24'h800000
  } state_t;

  localparam logic [23:0] PH_H = 24'h00000E;
  localparam logic [23:0] PH_S = 24'h000FF0;
  localparam logic [23:0] PH_B = 24'h007000;
  localparam logic [23:0] PH_O = 24'hFF8000;

  state_t           state_r, state_nxt;
  logic [SEG_W-1:0] nseg_r;
  logic [SEG_W-1:0] n_r, n_nxt;
  logic [SEG_W-1:0] k_r, k_nxt;
  logic [SEG_W-1:0] cnt_r, cnt_nxt;
  logic [SEG_W-1:0] n_act, km1, km2;

  // Segment count register, clamped to the supported range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nseg_r <= RST_SEGMENTS;
    end else if (cfg_we) begin
      nseg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (nseg_r < SEG_W'(2)) begin
      n_act = SEG_W'(2);
    end else if (nseg_r > SEG_W'(MAX_SEGMENTS)) begin
      n_act = SEG_W'(MAX_SEGMENTS);
    end else begin
      n_act = nseg_r;
    end
  end

  assign km1 = k_r - 1'b1;
  assign km2 = k_r - SEG_W'(2);

  // Sequencer: load, widths, forward sweep, back substitution, results.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.seg   = k_r;
    cmd.last  = (k_r == n_r);

    if (|(state_r & PH_H)) begin
      cmd.ra = k_r[IDX_W-1:0];
      cmd.rb = km1[IDX_W-1:0];
      cmd.wa = k_r[IDX_W-1:0];
    end
    if (|(state_r & PH_S)) begin
      cmd.ra      = km1[IDX_W-1:0];
      cmd.rb      = k_r[IDX_W-1:0];
      cmd.fa      = km2[IDX_W-1:0];
      cmd.wa      = km1[IDX_W-1:0];
      cmd.mask_fo = (k_r == SEG_W'(2));
    end
    if (|(state_r & PH_B)) begin
      cmd.fa      = km1[IDX_W-1:0];
      cmd.wa      = km1[IDX_W-1:0];
      cmd.mask_ck = (k_r == n_r);
    end
    if (|(state_r & PH_O)) begin
      cmd.ra      = k_r[IDX_W-1:0];
      cmd.rb      = km1[IDX_W-1:0];
      cmd.mask_ck = (k_r == n_r);
      cmd.mask_cp = (k_r == SEG_W'(1));
    end
    if (state_r == S_LOAD) begin
      cmd.wa = cnt_r[IDX_W-1:0];
    end

    unique case (state_r)
      S_LOAD: begin
        cmd.op = OP_CLR_BAD;
        if (in_valid) begin
          cmd.pt_we = 1'b1;
          if (cnt_r >= n_act) begin
            n_nxt     = n_act;
            k_nxt     = SEG_W'(1);
            cnt_nxt   = '0;
            state_nxt = S_H_RD;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_H_RD: state_nxt = S_H_DIV;
      S_H_DIV: begin
        cmd.op    = OP_H_DIV;
        state_nxt = S_H_WAIT;
      end
      S_H_WAIT: begin
        if (sts.div_done) begin
          cmd.hl_we = 1'b1;
          if (k_r == n_r) begin
            k_nxt     = SEG_W'(2);
            state_nxt = S_S_RD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_H_RD;
          end
        end
      end
      S_S_RD: state_nxt = S_S_MF;
      S_S_MF: begin
        cmd.op    = OP_S_MF;
        state_nxt = S_S_MO;
      end
      S_S_MO: begin
        cmd.op    = OP_S_MO;
        state_nxt = S_S_LM;
      end
      S_S_LM: begin
        cmd.op    = OP_S_LM;
        state_nxt = S_S_DF;
      end
      S_S_DF: begin
        cmd.op    = OP_S_DF;
        state_nxt = S_S_WF;
      end
      S_S_WF: begin
        if (sts.div_done) begin
          cmd.op    = OP_S_LF;
          state_nxt = S_S_DO;
        end
      end
      S_S_DO: begin
        cmd.op    = OP_S_DO;
        state_nxt = S_S_WO;
      end
      S_S_WO: begin
        if (sts.div_done) begin
          cmd.fo_we = 1'b1;
          if (k_r == n_r) begin
            state_nxt = S_B_RD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_S_RD;
          end
        end
      end
      S_B_RD: state_nxt = S_B_MUL;
      S_B_MUL: begin
        cmd.op    = OP_B_M;
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        cmd.c_we = 1'b1;
        if (k_r == SEG_W'(2)) begin
          k_nxt     = SEG_W'(1);
          state_nxt = S_O_RD;
        end else begin
          k_nxt     = km1;
          state_nxt = S_B_RD;
        end
      end
      S_O_RD: state_nxt = S_O_M1;
      S_O_M1: begin
        cmd.op    = OP_O_M1;
        state_nxt = S_O_M2;
      end
      S_O_M2: begin
        cmd.op    = OP_O_M2;
        state_nxt = S_O_LM;
      end
      S_O_LM: begin
        cmd.op    = OP_O_LM;
        state_nxt = S_O_D3;
      end
      S_O_D3: begin
        cmd.op    = OP_O_D3;
        state_nxt = S_O_W3;
      end
      S_O_W3: begin
        cmd.op    = OP_O_LB;
        state_nxt = S_O_DD;
      end
      S_O_DD: begin
        cmd.op    = OP_O_DD;
        state_nxt = S_O_WD;
      end
      S_O_WD: begin
        if (sts.div_done) begin
          cmd.op    = OP_O_OUT;
          state_nxt = S_O_OUT;
        end
      end
      S_O_OUT: begin
        if (sts.out_taken) begin
          if (k_r == n_r) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_O_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      k_r     <= '0;
      n_r     <= SEG_W'(2);
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_LOAD);

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_H_WAIT || state_r == S_S_WF || state_r == S_S_WO ||
                      state_r == S_O_WD))
    else $error("divider finished outside a wait state");
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> (k_r >= SEG_W'(1) && k_r <= n_r))
    else $error("segment counter out of range");
  a_take_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    sts.out_taken |-> state_r == S_O_OUT) else $error("result taken in wrong state");

endmodule

@@ design/natural_cubic_spline_coefficients.sv @@
// Loading accepts one point beat per cycle; the beat that completes a set starts the solve.
// The solve uses the shared radix-2 divider once per segment for the widths, twice per
// interior point in the forward sweep and once per segment for the results.
// Results then leave one beat per segment; the next set loads once the last is taken.
// Synchronous active-low reset returns to loading with no points held and 24 segments.
module natural_cubic_spline_coefficients import ncs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [SEG_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  ncs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stores, multiplier, divider and result register.
  ncs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

endmodule
